// ===== rtl/max_pool_2d_stream_assert.svh =====
// Assertion macros for the pooling block; clk_i and rst_ni must be in scope.
`ifndef MAX_POOL_2D_STREAM_ASSERT_SVH
`define MAX_POOL_2D_STREAM_ASSERT_SVH

`define MP2D_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("pooling invariant violated");

`define MP2D_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pooling sequence violated");

`endif

// ===== rtl/mp2d_pkg.sv =====
package mp2d_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int MAX_KERNEL  = 8;
  localparam int SAMPLE_BITS = 16;

  localparam int LINE_SLOTS = MAX_KERNEL - 1;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int NC_W       = COL_W + 1;
  localparam int KN_W       = $clog2(MAX_KERNEL + 1);
  localparam int ROW_W      = 16;
  localparam int KER_W      = 4;
  localparam int NCFG_W     = 11;
  localparam int OUT_COL_W  = 10;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_ROWS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COLS  = 3'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t MOST_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
  } tag_t;

  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] addr;
    sample_t          data;
    sample_t          mx;
    tag_t             tag;
  } beat_t;

  typedef struct packed {
    sample_t          pooled;
    logic             last;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
  } res_t;

endpackage

// ===== rtl/mp2d_line_cell.sv =====
module mp2d_line_cell
  import mp2d_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  use_i,
  input  beat_t link_i,
  output beat_t link_o
);

  sample_t          line_mem [MAX_COLS];
  logic             vld_q;
  logic [COL_W-1:0] addr_q;
  sample_t          rd_q;
  sample_t          mx_q;
  tag_t             tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= link_i.vld;
    end
  end

  // The stored sample of the row above is read out before the new one replaces it.
  always_ff @(posedge clk_i) begin
    if (en_i && link_i.vld) begin
      rd_q                  <= line_mem[link_i.addr];
      line_mem[link_i.addr] <= link_i.data;
      addr_q                <= link_i.addr;
      mx_q                  <= link_i.mx;
      tag_q                 <= link_i.tag;
    end
  end

  always_comb begin
    link_o.vld  = vld_q;
    link_o.addr = addr_q;
    link_o.data = rd_q;
    link_o.mx   = (use_i && (rd_q > mx_q)) ? rd_q : mx_q;
    link_o.tag  = tag_q;
  end

endmodule

// ===== rtl/mp2d_hmax.sv =====
module mp2d_hmax
  import mp2d_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [LINE_SLOTS-1:0] col_use_i,
  input  beat_t                 link_i,
  output logic                  res_vld_o,
  output res_t                  res_o
);

  localparam int NPAIR = (MAX_KERNEL + 1) / 2;

  sample_t hist_q [LINE_SLOTS];
  sample_t cand   [2 * NPAIR];
  sample_t pair_d [NPAIR];
  sample_t pair_q [NPAIR];
  logic    vld_q;
  tag_t    tag_q;
  sample_t best;

  always_comb begin
    for (int i = 0; i < 2 * NPAIR; i++) begin
      cand[i] = MOST_NEG;
    end
    cand[0] = link_i.mx;
    for (int i = 0; i < LINE_SLOTS; i++) begin
      if (col_use_i[i]) begin
        cand[i + 1] = hist_q[i];
      end
    end
    for (int p = 0; p < NPAIR; p++) begin
      pair_d[p] = (cand[2 * p] > cand[2 * p + 1]) ? cand[2 * p] : cand[2 * p + 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= link_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && link_i.vld) begin
      hist_q[0] <= link_i.mx;
      for (int i = 1; i < LINE_SLOTS; i++) begin
        hist_q[i] <= hist_q[i - 1];
      end
    end
    if (en_i) begin
      pair_q <= pair_d;
      tag_q  <= link_i.tag;
    end
  end

  always_comb begin
    best = pair_q[0];
    for (int p = 1; p < NPAIR; p++) begin
      if (pair_q[p] > best) begin
        best = pair_q[p];
      end
    end
    res_vld_o    = vld_q && tag_q.emit;
    res_o.pooled = best;
    res_o.last   = tag_q.last;
    res_o.orow   = tag_q.orow;
    res_o.ocol   = tag_q.ocol;
  end

endmodule

// ===== rtl/max_pool_2d_stream.sv =====
// Throughput: one sample beat per cycle, set by the single read and single write per cycle of
// the line memory in each of the seven line cells; beats keep flowing while a skid register has room.
// The sample beat that completes a window passes seven line cells, one reduction register and the output
// register (the skid register in between when the output stalls) before its result beat is presented.
// Reset clears the pipeline valid bits, the plane position and the registers to a 2x2 window,
// stride 2 and a 32x32 plane; line memory contents stay undefined until written.
`include "max_pool_2d_stream_assert.svh"

module max_pool_2d_stream
  import mp2d_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] pooled_o,
  output logic [ROW_W-1:0]       out_row_o,
  output logic [OUT_COL_W-1:0]   out_col_o,
  output logic                   plane_done_o
);

  logic [KER_W-1:0]  kernel_rows_q, kernel_cols_q, step_rows_q, step_cols_q;
  logic [ROW_W-1:0]  plane_rows_q;
  logic [NCFG_W-1:0] plane_cols_q;

  logic [KN_W-1:0]  kr, kc;
  logic [KER_W-1:0] sr, sc;
  logic [ROW_W-1:0] nr;
  logic [NC_W-1:0]  nc;

  logic [ROW_W-1:0] row_q, row_d, orow_q, orow_d;
  logic [COL_W-1:0] col_q, col_d, ocol_q, ocol_d;
  logic [KER_W-1:0] rph_q, rph_d, cph_q, cph_d;

  logic row_ge, col_ge, row_last, col_last, last_r, last_c, emit;
  logic adv, acc;

  logic [LINE_SLOTS-1:0] row_use, col_use;
  beat_t                 link [LINE_SLOTS + 1];

  logic res_vld;
  res_t res;
  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  res_t out_q, skid_q;
  logic pop, push, load_out, load_skid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_rows_q <= KER_W'(2);
      kernel_cols_q <= KER_W'(2);
      step_rows_q   <= KER_W'(2);
      step_cols_q   <= KER_W'(2);
      plane_rows_q  <= ROW_W'(32);
      plane_cols_q  <= NCFG_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KERNEL_ROWS: kernel_rows_q <= cfg_data_i[KER_W-1:0];
        CFG_KERNEL_COLS: kernel_cols_q <= cfg_data_i[KER_W-1:0];
        CFG_STEP_ROWS:   step_rows_q   <= cfg_data_i[KER_W-1:0];
        CFG_STEP_COLS:   step_cols_q   <= cfg_data_i[KER_W-1:0];
        CFG_PLANE_ROWS:  plane_rows_q  <= cfg_data_i[ROW_W-1:0];
        CFG_PLANE_COLS:  plane_cols_q  <= cfg_data_i[NCFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (kernel_rows_q == '0) begin
      kr = KN_W'(1);
    end else if (32'(kernel_rows_q) > 32'(MAX_KERNEL)) begin
      kr = KN_W'(MAX_KERNEL);
    end else begin
      kr = KN_W'(kernel_rows_q);
    end
    if (kernel_cols_q == '0) begin
      kc = KN_W'(1);
    end else if (32'(kernel_cols_q) > 32'(MAX_KERNEL)) begin
      kc = KN_W'(MAX_KERNEL);
    end else begin
      kc = KN_W'(kernel_cols_q);
    end
    sr = (step_rows_q == '0) ? KER_W'(1) : step_rows_q;
    sc = (step_cols_q == '0) ? KER_W'(1) : step_cols_q;
    nr = (plane_rows_q == '0) ? ROW_W'(1) : plane_rows_q;
    if (plane_cols_q == '0) begin
      nc = NC_W'(1);
    end else if (32'(plane_cols_q) > 32'(MAX_COLS)) begin
      nc = NC_W'(MAX_COLS);
    end else begin
      nc = NC_W'(plane_cols_q);
    end
    for (int k = 0; k < LINE_SLOTS; k++) begin
      row_use[k] = (32'(k) + 32'd1) < 32'(kr);
      col_use[k] = (32'(k) + 32'd1) < 32'(kc);
    end
  end

  always_comb begin
    row_ge   = (32'(row_q) + 32'd1) >= 32'(kr);
    col_ge   = (32'(col_q) + 32'd1) >= 32'(kc);
    row_last = (32'(row_q) + 32'd1) >= 32'(nr);
    col_last = (32'(col_q) + 32'd1) >= 32'(nc);
    last_r   = (32'(row_q) + 32'(sr)) >= 32'(nr);
    last_c   = (32'(col_q) + 32'(sc)) >= 32'(nc);
    emit     = row_ge && col_ge && (rph_q == '0) && (cph_q == '0);
  end

  assign adv        = !skid_vld_q;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    rph_d  = rph_q;
    cph_d  = cph_q;
    orow_d = orow_q;
    ocol_d = ocol_q;
    if (cfg_we_i) begin
      row_d  = '0;
      col_d  = '0;
      rph_d  = '0;
      cph_d  = '0;
      orow_d = '0;
      ocol_d = '0;
    end else if (acc) begin
      if (col_last) begin
        col_d  = '0;
        cph_d  = '0;
        ocol_d = '0;
        if (row_last) begin
          row_d  = '0;
          rph_d  = '0;
          orow_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
          if (!row_ge) begin
            rph_d  = '0;
            orow_d = '0;
          end else if (rph_q == sr - KER_W'(1)) begin
            rph_d  = '0;
            orow_d = orow_q + ROW_W'(1);
          end else begin
            rph_d = rph_q + KER_W'(1);
          end
        end
      end else begin
        col_d = col_q + COL_W'(1);
        if (!col_ge) begin
          cph_d  = '0;
          ocol_d = '0;
        end else if (cph_q == sc - KER_W'(1)) begin
          cph_d  = '0;
          ocol_d = ocol_q + COL_W'(1);
        end else begin
          cph_d = cph_q + KER_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      rph_q  <= '0;
      cph_q  <= '0;
      orow_q <= '0;
      ocol_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      rph_q  <= rph_d;
      cph_q  <= cph_d;
      orow_q <= orow_d;
      ocol_q <= ocol_d;
    end
  end

  always_comb begin
    link[0].vld      = acc;
    link[0].addr     = col_q;
    link[0].data     = sample_t'(sample_i);
    link[0].mx       = sample_t'(sample_i);
    link[0].tag.emit = emit;
    link[0].tag.last = last_r && last_c;
    link[0].tag.orow = orow_q;
    link[0].tag.ocol = ocol_q;
  end

  for (genvar k = 0; k < LINE_SLOTS; k++) begin : g_cell
    mp2d_line_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .use_i  (row_use[k]),
      .link_i (link[k]),
      .link_o (link[k + 1])
    );
  end

  mp2d_hmax u_hmax (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .col_use_i (col_use),
    .link_i    (link[LINE_SLOTS]),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_comb begin
    pop        = out_vld_q && out_ready_i;
    push       = adv && res_vld;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    if (skid_vld_q) begin
      if (pop) begin
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
        load_out   = 1'b1;
      end
    end else if (!out_vld_q || pop) begin
      out_vld_d = push;
      load_out  = push;
    end else if (push) begin
      skid_vld_d = 1'b1;
      load_skid  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_vld_q ? skid_q : res;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign pooled_o     = out_q.pooled;
  assign out_row_o    = out_q.orow;
  assign out_col_o    = OUT_COL_W'(out_q.ocol);
  assign plane_done_o = out_q.last;

  `MP2D_ASSERT(a_skid_behind_out, !skid_vld_q || out_vld_q)
  `MP2D_ASSERT(a_col_in_plane, 32'(col_q) < 32'(nc))
  `MP2D_ASSERT(a_phase_below_step, (rph_q < sr) && (cph_q < sc))
  `MP2D_ASSERT_NEXT(a_skid_holds_on_stall, skid_vld_q && !out_ready_i, skid_vld_q && out_vld_q)

endmodule

// ===== tb/max_pool_2d_stream_checker.sv =====
`timescale 1ns / 1ps

module max_pool_2d_stream_checker
  import mp2d_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [15:0]           sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [15:0]           pooled_i,
  input  logic [ROW_W-1:0]      out_row_i,
  input  logic [OUT_COL_W-1:0]  out_col_i,
  input  logic                  plane_done_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  typedef struct packed {
    sample_t                pooled;
    logic [ROW_W-1:0]       orow;
    logic [OUT_COL_W-1:0]   ocol;
    logic                   last;
  } window_max_t;

  logic [KER_W-1:0]  win_rows_q;
  logic [KER_W-1:0]  win_cols_q;
  logic [KER_W-1:0]  hop_rows_q;
  logic [KER_W-1:0]  hop_cols_q;
  logic [ROW_W-1:0]  plane_rows_q;
  logic [NCFG_W-1:0] plane_cols_q;

  int unsigned row_pos;
  int unsigned col_pos;
  sample_t     plane_lines [MAX_KERNEL][MAX_COLS];
  window_max_t expected_maxima [$];
  int unsigned mismatch_count;

  assign errors_o = mismatch_count;

  function automatic int unsigned clip(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(input string msg);
    $display("%0t  %s", $time, msg);
    mismatch_count++;
  endtask

  // The last MAX_KERNEL rows of the plane are kept whole, so every window is a plain
  // maximum over rows and columns that already arrived in this plane.
  task automatic predict_window(input sample_t x);
    int unsigned kr, kc, sr, sc, nr, nc;
    int unsigned i, j;
    int unsigned orow, ocol;
    sample_t     best;
    sample_t     v;
    window_max_t w;
    kr = clip(win_rows_q, MAX_KERNEL);
    kc = clip(win_cols_q, MAX_KERNEL);
    sr = clip(hop_rows_q, 15);
    sc = clip(hop_cols_q, 15);
    nr = clip(plane_rows_q, 65535);
    nc = clip(plane_cols_q, MAX_COLS);
    plane_lines[row_pos % MAX_KERNEL][col_pos] = x;
    if (row_pos + 1 >= kr && col_pos + 1 >= kc &&
        (row_pos + 1 - kr) % sr == 0 && (col_pos + 1 - kc) % sc == 0) begin
      best = MOST_NEG;
      for (i = 0; i < kr; i++) begin
        for (j = 0; j < kc; j++) begin
          v = plane_lines[(row_pos - i) % MAX_KERNEL][col_pos - j];
          if (v > best) best = v;
        end
      end
      orow = (row_pos + 1 - kr) / sr;
      ocol = (col_pos + 1 - kc) / sc;
      w.pooled = best;
      w.orow   = orow[ROW_W-1:0];
      w.ocol   = ocol[OUT_COL_W-1:0];
      w.last   = (orow == (nr - kr) / sr) && (ocol == (nc - kc) / sc);
      expected_maxima.push_back(w);
    end
    if (col_pos + 1 >= nc) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= nr) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    window_max_t w;
    if (!rst_ni) begin
      win_rows_q   = 4'd2;
      win_cols_q   = 4'd2;
      hop_rows_q   = 4'd2;
      hop_cols_q   = 4'd2;
      plane_rows_q = 16'd32;
      plane_cols_q = 11'd32;
      row_pos      = 0;
      col_pos      = 0;
      expected_maxima.delete();
      mismatch_count = 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_maxima.size() == 0) begin
          report($sformatf("result beat with nothing pending: pooled %h row %0d col %0d",
                           pooled_i, out_row_i, out_col_i));
        end else begin
          w = expected_maxima.pop_front();
          if (pooled_i !== w.pooled)
            report($sformatf("pooled: got %h, expected %h", pooled_i, w.pooled));
          if (out_row_i !== w.orow)
            report($sformatf("out_row: got %0d, expected %0d", out_row_i, w.orow));
          if (out_col_i !== w.ocol)
            report($sformatf("out_col: got %0d, expected %0d", out_col_i, w.ocol));
          if (plane_done_i !== w.last)
            report($sformatf("plane_done: got %b, expected %b", plane_done_i, w.last));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KERNEL_ROWS: win_rows_q   = cfg_data_i[KER_W-1:0];
          CFG_KERNEL_COLS: win_cols_q   = cfg_data_i[KER_W-1:0];
          CFG_STEP_ROWS:   hop_rows_q   = cfg_data_i[KER_W-1:0];
          CFG_STEP_COLS:   hop_cols_q   = cfg_data_i[KER_W-1:0];
          CFG_PLANE_ROWS:  plane_rows_q = cfg_data_i[ROW_W-1:0];
          CFG_PLANE_COLS:  plane_cols_q = cfg_data_i[NCFG_W-1:0];
          default: ;
        endcase
        row_pos = 0;
        col_pos = 0;
      end
      if (in_valid_i && in_ready_i) predict_window(sample_i);
      pending_o <= expected_maxima.size();
    end
  end

endmodule

// ===== tb/max_pool_2d_stream_tb.sv =====
`timescale 1ns / 1ps

module max_pool_2d_stream_tb
  import mp2d_pkg::*;
;

  localparam sample_t MOST_POS = 16'sh7fff;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 820;
  localparam int unsigned DRAIN_CYCLES = 24;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [15:0]           sample_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [15:0]           pooled_o;
  logic [ROW_W-1:0]      out_row_o;
  logic [OUT_COL_W-1:0]  out_col_o;
  logic                  plane_done_o;

  int unsigned pending;
  int unsigned errors;
  bit          in_burst  = 1'b0;
  bit          out_burst = 1'b0;
  int unsigned random_sent;

  max_pool_2d_stream uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pooled_o    (pooled_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .plane_done_o(plane_done_o)
  );

  max_pool_2d_stream_checker pool_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .pooled_i    (pooled_o),
    .out_row_i   (out_row_o),
    .out_col_i   (out_col_o),
    .plane_done_i(plane_done_o),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [15:0] draw_sample();
    case ($urandom_range(0, 15))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return 16'($urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] v);
    int unsigned gap;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random_samples(input int unsigned count);
    repeat (count) send_sample(draw_sample());
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_window(input logic [CFG_DATA_W-1:0] kr, input logic [CFG_DATA_W-1:0] kc,
                                input logic [CFG_DATA_W-1:0] sr, input logic [CFG_DATA_W-1:0] sc,
                                input logic [CFG_DATA_W-1:0] pr, input logic [CFG_DATA_W-1:0] pc);
    write_reg(CFG_KERNEL_ROWS, kr);
    write_reg(CFG_KERNEL_COLS, kc);
    write_reg(CFG_STEP_ROWS, sr);
    write_reg(CFG_STEP_COLS, sc);
    write_reg(CFG_PLANE_ROWS, pr);
    write_reg(CFG_PLANE_COLS, pc);
    cfg_we_i <= 1'b0;
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [CFG_DATA_W-1:0] draw_kernel_field();
    logic [CFG_DATA_W-1:0] d;
    d = 16'($urandom);
    d[KER_W-1:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 3));
    return d;
  endfunction

  task automatic program_random_window();
    logic [CFG_DATA_W-1:0] rows;
    logic [CFG_DATA_W-1:0] cols;
    rows = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 20));
    cols = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       cols[NCFG_W-1:0] = 11'($urandom_range(25, 1024));
      1:       cols[NCFG_W-1:0] = 11'($urandom_range(1025, 2047));
      default: cols[NCFG_W-1:0] = 11'($urandom_range(0, 24));
    endcase
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
    program_window(draw_kernel_field(), draw_kernel_field(), draw_kernel_field(),
                   draw_kernel_field(), rows, cols);
  endtask

  initial begin
    @(posedge clk_i);
    forever begin
      int unsigned stall;
      stall = draw_wait(out_burst);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    #8_000_000;
    $display("[max_pool_2d_stream] ERROR");
    $finish;
  end

  initial begin
    int unsigned count;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero kernel, stride and height act as one; every sample is its own window.
    program_window(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd3);
    send_sample(MOST_POS);
    send_sample(MOST_NEG);
    send_sample(16'hffff);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'h0100);
    in_valid_i <= 1'b0;
    wait_drained();

    // A window larger than the plane consumes samples and gives nothing.
    program_window(16'd3, 16'd3, 16'd1, 16'd1, 16'd2, 16'd2);
    send_random_samples(4);
    wait_drained();

    // A write to an index outside the register list still restarts the plane.
    program_window(16'd1, 16'd2, 16'd1, 16'd1, 16'd2, 16'd4);
    send_random_samples(3);
    wait_drained();
    write_reg(CFG_SPARE_LO, 16'hffff);
    cfg_we_i <= 1'b0;
    send_random_samples(5);
    wait_drained();

    // Oversized kernel clamps to eight rows and columns.
    program_window(16'd15, 16'd9, 16'd1, 16'd1, 16'd9, 16'd10);
    send_random_samples(90);
    wait_drained();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      program_random_window();
      count = $urandom_range(8, 160);
      send_random_samples(count);
      random_sent += count;
      wait_drained();
    end

    if (errors == 0) begin
      $display("[max_pool_2d_stream] OK");
    end else begin
      $display("[max_pool_2d_stream] ERROR");
    end
    $finish;
  end

endmodule
